### design/qesm_pkg.sv
package qesm_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned DivCfgW = 8;
    localparam int unsigned CoefW  = 16;

    // shared divider: dividend and divisor widths
    localparam int unsigned QdW = 53;
    localparam int unsigned QsW = 32;

    // shared multiplier: signed multiplicand, unsigned multiplier, signed product
    localparam int unsigned McW = 34;
    localparam int unsigned MrW = 20;
    localparam int unsigned MpW = 54;

    localparam logic [DivCfgW-1:0] DividerRst = 8'd1;
    localparam logic [TimeW-1:0]   TimeoutRst = 32'd100000;
    localparam logic [CoefW-1:0]   CoeffRst   = 16'd32768;
    localparam logic [MrW-1:0]     UsPerSec   = 20'd1000000;

    typedef enum logic [1:0] {
        CFG_DIVIDER = 2'd0,
        CFG_SPEED_K = 2'd1,
        CFG_TIMEOUT = 2'd2,
        CFG_COEFF   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

### design/quadrature_encoder_speed_meter.sv
// Encoder speed meter, period method, Q8 RPM. A tick request is taken whenever the block is idle
// and never stalls the input. A query request stalls the input while it runs: the raw speed and
// the acceleration each take one pass of the shared 53-step restoring divider, and the filter and
// the scaling by one million each take one 20-step pass of the shared shift-add multiplier. The
// raw speed pass is skipped when the speed reads as zero, and the acceleration passes are skipped
// when the query gap is zero. The result sits in an output register, so a query may run while the
// previous result still waits; it then holds in its last state, with the input stalled, until
// that result is taken.
// Configuration writes are always ready and take effect at once.
module quadrature_encoder_speed_meter
    import qesm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic               i_count_down,
    input  logic [TimeW-1:0]   i_time_us,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_speed_q8,
    output logic signed [31:0] o_accel_rpm_per_s,
    output logic signed [31:0] o_position,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DIV1    = 9'b000000010,
        S_FLT_LD  = 9'b000000100,
        S_MUL1    = 9'b000001000,
        S_ACC_LD  = 9'b000010000,
        S_MUL2    = 9'b000100000,
        S_DIV2_LD = 9'b001000000,
        S_DIV2    = 9'b010000000,
        S_FIN     = 9'b100000000
    } t_state;

    localparam int unsigned FltW = MpW - 16;

    t_state             r_state;

    logic [DivCfgW-1:0] r_divider;
    logic [31:0]        r_speed_k;
    logic [TimeW-1:0]   r_timeout;
    logic [CoefW-1:0]   r_coeff;

    logic [7:0]         r_pre;
    logic               r_dir;
    logic [31:0]        r_pos;
    logic [TimeW-1:0]   r_last_tick;
    logic [TimeW-1:0]   r_interval;
    logic [31:0]        r_filt;
    logic [TimeW-1:0]   r_last_q;

    logic [31:0]        r_prev;
    logic [TimeW-1:0]   r_dt;
    logic [32:0]        r_raw;
    logic [QdW-1:0]     r_mag;
    logic               r_neg;
    logic [31:0]        r_accel;

    logic               r_o_valid;
    logic [31:0]        r_o_speed;
    logic [31:0]        r_o_accel;
    logic [31:0]        r_o_pos;

    logic               w_in_acc;
    logic               w_tick;
    logic               w_query;
    logic [7:0]         w_pre_inc;
    logic [TimeW-1:0]   w_age;
    logic               w_raw_ok;

    logic               w_div_start;
    logic [QdW-1:0]     w_div_dvd;
    logic [QsW-1:0]     w_div_dsr;
    t_unit_sts          w_div_sts;
    logic [QdW-1:0]     w_div_q;

    logic               w_mul_start;
    logic [McW-1:0]     w_mul_mc;
    logic [MrW-1:0]     w_mul_mr;
    t_unit_sts          w_mul_sts;
    logic [MpW-1:0]     w_mul_p;

    logic [FltW-1:0]    w_flt_sum;
    logic [FltW-32:0]   w_flt_hi;
    logic [31:0]        w_flt_sat;
    logic [MpW-1:0]     w_abs;
    logic [31:0]        w_acc_sat;
    logic               w_out_free;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_tick      = w_in_acc && !i_req_type;
    assign w_query     = w_in_acc && i_req_type;
    assign w_pre_inc   = (r_pre != 8'hFF) ? (r_pre + 8'd1) : r_pre;
    assign w_age       = i_time_us - r_last_tick;
    assign w_raw_ok    = (w_age <= r_timeout) && (r_interval != '0);
    assign w_out_free  = !r_o_valid || !i_stall;

    assign w_div_start = (w_query && w_raw_ok) || (r_state == S_DIV2_LD);
    assign w_div_dvd   = (r_state == S_IDLE) ? {{(QdW-32){1'b0}}, r_speed_k} : r_mag;
    assign w_div_dsr   = (r_state == S_IDLE) ? r_interval : r_dt;

    assign w_mul_start = (r_state == S_FLT_LD) || (r_state == S_ACC_LD);
    assign w_mul_mc    = (r_state == S_FLT_LD)
                       ? ({{(McW-32){r_prev[31]}}, r_prev} - {{(McW-33){r_raw[32]}}, r_raw})
                       : ({{(McW-32){r_filt[31]}}, r_filt} - {{(McW-32){r_prev[31]}}, r_prev});
    assign w_mul_mr    = (r_state == S_FLT_LD) ? {{(MrW-CoefW){1'b0}}, r_coeff} : UsPerSec;

    // new = raw + floor(c * (prev - raw) / 2^16)
    assign w_flt_sum = {{(FltW-33){r_raw[32]}}, r_raw} + w_mul_p[MpW-1:16];
    assign w_flt_hi  = w_flt_sum[FltW-1:31];
    assign w_flt_sat = ((|w_flt_hi) && !(&w_flt_hi))
                     ? (w_flt_sum[FltW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                     : w_flt_sum[31:0];

    assign w_abs = w_mul_p[MpW-1] ? (~w_mul_p + MpW'(1)) : w_mul_p;

    always_comb begin
        if (r_neg) begin
            if ((|w_div_q[QdW-1:32]) || (w_div_q[31] && (|w_div_q[30:0]))) begin
                w_acc_sat = 32'h8000_0000;
            end else begin
                w_acc_sat = ~w_div_q[31:0] + 32'd1;
            end
        end else begin
            if (|w_div_q[QdW-1:31]) begin
                w_acc_sat = 32'h7FFF_FFFF;
            end else begin
                w_acc_sat = w_div_q[31:0];
            end
        end
    end

    qesm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_sts      (w_div_sts),
        .o_quotient (w_div_q)
    );

    qesm_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_mul_mc),
        .i_mplier  (w_mul_mr),
        .o_sts     (w_mul_sts),
        .o_product (w_mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider <= DividerRst;
            r_speed_k <= '0;
            r_timeout <= TimeoutRst;
            r_coeff   <= CoeffRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIVIDER: r_divider <= i_cfg_data[DivCfgW-1:0];
                CFG_SPEED_K: r_speed_k <= i_cfg_data;
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_COEFF:   r_coeff   <= i_cfg_data[CoefW-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pre       <= '0;
            r_dir       <= 1'b0;
            r_pos       <= '0;
            r_last_tick <= '0;
            r_interval  <= '0;
            r_filt      <= '0;
            r_last_q    <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_tick) begin
                        if (w_pre_inc >= r_divider) begin
                            r_dir       <= i_count_down;
                            r_pos       <= i_count_down ? (r_pos - 32'd1) : (r_pos + 32'd1);
                            r_interval  <= i_time_us - r_last_tick;
                            r_last_tick <= i_time_us;
                            r_pre       <= '0;
                        end else begin
                            r_pre <= w_pre_inc;
                        end
                    end else if (w_query) begin
                        r_last_q <= i_time_us;
                        r_state  <= w_raw_ok ? S_DIV1 : S_FLT_LD;
                    end
                end
                S_DIV1: begin
                    if (w_div_sts.done) begin
                        r_state <= S_FLT_LD;
                    end
                end
                S_FLT_LD: r_state <= S_MUL1;
                S_MUL1: begin
                    if (w_mul_sts.done) begin
                        r_filt  <= w_flt_sat;
                        r_state <= (r_dt == '0) ? S_FIN : S_ACC_LD;
                    end
                end
                S_ACC_LD: r_state <= S_MUL2;
                S_MUL2: begin
                    if (w_mul_sts.done) begin
                        r_state <= S_DIV2_LD;
                    end
                end
                S_DIV2_LD: r_state <= S_DIV2;
                S_DIV2: begin
                    if (w_div_sts.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // query working registers
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_prev  <= r_filt;
            r_dt    <= i_time_us - r_last_q;
            r_raw   <= '0;
            r_accel <= '0;
        end
        if ((r_state == S_DIV1) && w_div_sts.done) begin
            r_raw <= r_dir ? (~{1'b0, w_div_q[31:0]} + 33'd1) : {1'b0, w_div_q[31:0]};
        end
        if ((r_state == S_MUL2) && w_mul_sts.done) begin
            r_neg <= w_mul_p[MpW-1];
            r_mag <= w_abs[QdW-1:0];
        end
        if ((r_state == S_DIV2) && w_div_sts.done) begin
            r_accel <= w_acc_sat;
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_o_speed <= r_filt;
            r_o_accel <= r_accel;
            r_o_pos   <= r_pos;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_speed_q8        = $signed(r_o_speed);
    assign o_accel_rpm_per_s = $signed(r_o_accel);
    assign o_position        = $signed(r_o_pos);

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN))
        else $error("result shown without a finished query");

    a_query_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_req_type) |=> o_stall)
        else $error("query request did not stall the input");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_sts.busy && w_mul_sts.busy))
        else $error("divider and multiplier busy together");

    a_tick_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_req_type && !o_valid) |=> !o_valid)
        else $error("tick request produced a result");

endmodule

### design/qesm_div.sv
module qesm_div
    import qesm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [QdW-1:0] i_dividend,
    input  logic [QsW-1:0] i_divisor,
    output t_unit_sts      o_sts,
    output logic [QdW-1:0] o_quotient
);

    localparam int unsigned CntW = $clog2(QdW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [QsW-1:0]  r_rem;
    logic [QdW-1:0]  r_quo;
    logic [QsW-1:0]  r_dsr;

    logic [QsW:0]    w_trial;
    logic [QsW+1:0]  w_sub;
    logic            w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[QdW-1]};
    assign w_sub   = {1'b0, w_trial} - {2'b00, r_dsr};
    assign w_ge    = ~w_sub[QsW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(QdW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[QsW-1:0] : w_trial[QsW-1:0];
            r_quo <= {r_quo[QdW-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

### design/qesm_mul.sv
module qesm_mul
    import qesm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [McW-1:0] i_mcand,
    input  logic [MrW-1:0] i_mplier,
    output t_unit_sts      o_sts,
    output logic [MpW-1:0] o_product
);

    localparam int unsigned CntW = $clog2(MrW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [MpW-1:0]  r_acc;
    logic [MpW-1:0]  r_mc;
    logic [MrW-1:0]  r_mr;

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(MrW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= {{(MpW-McW){i_mcand[McW-1]}}, i_mcand};
            r_mr  <= i_mplier;
        end else if (r_busy) begin
            if (r_mr[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= {r_mc[MpW-2:0], 1'b0};
            r_mr <= {1'b0, r_mr[MrW-1:1]};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_product  = r_acc;

endmodule
